// ===== design/sgeq_pkg.sv =====
// ----------------------------------------------------------------------------
// sgeq_pkg
// Shared types and constants of the stereo graphic equalizer.
// ----------------------------------------------------------------------------
package sgeq_pkg;

  localparam int DEF_BAND_COUNT     = 31;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 28;

  localparam int GUARD_BITS = 8;
  localparam int COEF_BITS  = 32;
  localparam int COEF_SLOTS = 5;
  localparam int HIST_TAPS  = 4;
  localparam int MIX_SHIFT  = 15;

  localparam logic [16:0] MIX_ONE   = 17'd32768;
  localparam logic [15:0] MIX_RESET = 16'd32768;

  // coefficient slot codes
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // register indexes
  localparam logic REG_MIX    = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  // item modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRD,
    ST_CWR,
    ST_RD,
    ST_MAC,
    ST_WB,
    ST_BLEND,
    ST_DONE
  } eng_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } eng_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

// ===== design/sgeq_ram.sv =====
// ----------------------------------------------------------------------------
// sgeq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sgeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sgeq_engine.sv =====
// ----------------------------------------------------------------------------
// sgeq_engine
// Biquad sequencer: history and coefficient rows in RAM, one shared
// multiplier, per-channel accumulators and the dry/wet blend.
// ----------------------------------------------------------------------------
module sgeq_engine #(
  parameter int BAND_COUNT     = sgeq_pkg::DEF_BAND_COUNT,
  parameter int SAMPLE_BITS    = sgeq_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = sgeq_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sgeq_pkg::eng_ctrl_t           ctrl,
  output sgeq_pkg::eng_stat_t           stat,
  input  logic                          mode,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic [4:0]                    band,
  input  logic [2:0]                    coef_slot,
  input  logic signed [31:0]            coef_value,
  input  logic [15:0]                   mix_level,
  input  logic                          enable,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  import sgeq_pkg::*;

  localparam int IB   = SAMPLE_BITS + GUARD_BITS;
  localparam int BAW  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int CROW = COEF_SLOTS * COEF_BITS;
  localparam int HROW = HIST_TAPS * IB;
  localparam int PW   = COEF_BITS + IB;
  localparam int AW   = PW + 3;

  localparam logic [BAW-1:0] LAST_BAND = BAW'(BAND_COUNT - 1);
  localparam logic [CROW-1:0] IDENT_ROW =
    {{(CROW - COEF_BITS){1'b0}}, COEF_BITS'(64'd1 << COEF_FRAC_BITS)};
  localparam logic signed [AW-1:0] IMAX = {{(AW-IB+1){1'b0}}, {(IB-1){1'b1}}};
  localparam logic signed [AW-1:0] IMIN = {{(AW-IB+1){1'b1}}, {(IB-1){1'b0}}};
  localparam logic signed [AW-1:0] SMAX =
    {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN =
    {{(AW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  eng_state_t state, state_next;

  logic [BAW-1:0]               band_cnt;
  logic [3:0]                   k;
  logic [2:0]                   c_slot;
  logic signed [COEF_BITS-1:0]  c_value;
  logic signed [SAMPLE_BITS-1:0] dry_l, dry_r;
  logic signed [IB-1:0]         x_l, x_r;
  logic signed [AW-1:0]         acc_l, acc_r;
  logic signed [PW-1:0]         prod;
  logic                         p_vld, p_ch, p_neg, p_raw;
  logic [BAND_COUNT-1:0]        hist_valid, coef_valid;
  logic                         hv, cv;

  logic              c_re, c_we, h_re, h_we;
  logic [CROW-1:0]   c_rdata, c_wdata, crow;
  logic [HROW-1:0]   hl_rdata, hr_rdata, hl_wdata, hr_wdata, hrow_l, hrow_r;

  logic                        i_vld, i_ch, i_neg, i_raw;
  logic [2:0]                  sl;
  logic signed [COEF_BITS-1:0] op_a;
  logic signed [IB-1:0]        op_b;
  logic signed [AW-1:0]        term;
  logic signed [IB-1:0]        y_l, y_r;
  logic signed [AW-1:0]        v_l, v_r;
  logic [16:0]                 w_wet, w_dry;
  logic                        coef_ok;

  sgeq_ram #(.WIDTH(CROW), .DEPTH(BAND_COUNT)) u_coef_ram (
    .clk(clk), .we(c_we), .waddr(band_cnt), .wdata(c_wdata),
    .re(c_re), .raddr(band_cnt), .rdata(c_rdata)
  );

  sgeq_ram #(.WIDTH(HROW), .DEPTH(BAND_COUNT)) u_hist_l_ram (
    .clk(clk), .we(h_we), .waddr(band_cnt), .wdata(hl_wdata),
    .re(h_re), .raddr(band_cnt), .rdata(hl_rdata)
  );

  sgeq_ram #(.WIDTH(HROW), .DEPTH(BAND_COUNT)) u_hist_r_ram (
    .clk(clk), .we(h_we), .waddr(band_cnt), .wdata(hr_wdata),
    .re(h_re), .raddr(band_cnt), .rdata(hr_rdata)
  );

  // never-written rows read as their reset contents
  assign crow   = cv ? c_rdata : IDENT_ROW;
  assign hrow_l = hv ? hl_rdata : '0;
  assign hrow_r = hv ? hr_rdata : '0;

  assign w_wet = (mix_level > 16'(MIX_ONE)) ? MIX_ONE : {1'b0, mix_level};
  assign w_dry = MIX_ONE - w_wet;

  assign coef_ok = ({2'b00, band} < 7'(BAND_COUNT)) && (coef_slot <= SLOT_A2);

  always_comb begin
    y_l = (acc_l > IMAX) ? IMAX[IB-1:0] : ((acc_l < IMIN) ? IMIN[IB-1:0] : acc_l[IB-1:0]);
    y_r = (acc_r > IMAX) ? IMAX[IB-1:0] : ((acc_r < IMIN) ? IMIN[IB-1:0] : acc_r[IB-1:0]);
    v_l = acc_l >>> MIX_SHIFT;
    v_r = acc_r >>> MIX_SHIFT;
    left_out  = (v_l > SMAX) ? SMAX[SAMPLE_BITS-1:0] :
                ((v_l < SMIN) ? SMIN[SAMPLE_BITS-1:0] : v_l[SAMPLE_BITS-1:0]);
    right_out = (v_r > SMAX) ? SMAX[SAMPLE_BITS-1:0] :
                ((v_r < SMIN) ? SMIN[SAMPLE_BITS-1:0] : v_r[SAMPLE_BITS-1:0]);
    hl_wdata = {hrow_l[2*IB +: IB], y_l, hrow_l[0 +: IB], x_l};
    hr_wdata = {hrow_r[2*IB +: IB], y_r, hrow_r[0 +: IB], x_r};
    c_wdata = crow;
    c_wdata[int'(c_slot)*COEF_BITS +: COEF_BITS] = c_value;
    term = p_raw ? AW'(prod) : AW'(prod >>> COEF_FRAC_BITS);
  end

  // operand select for the shared multiplier
  always_comb begin
    i_vld = 1'b0;
    i_ch  = 1'b0;
    i_neg = 1'b0;
    i_raw = 1'b0;
    sl    = SLOT_B0;
    op_a  = '0;
    op_b  = '0;
    case (state)
      ST_MAC: begin
        i_vld = (k < 4'd10);
        i_ch  = (k >= 4'd5);
        sl    = i_ch ? 3'(k - 4'd5) : k[2:0];
        i_neg = (sl == SLOT_A1) || (sl == SLOT_A2);
        op_a  = crow[int'(sl)*COEF_BITS +: COEF_BITS];
        case (sl)
          SLOT_B0: op_b = i_ch ? x_r : x_l;
          SLOT_B1: op_b = i_ch ? hrow_r[0*IB +: IB] : hrow_l[0*IB +: IB];
          SLOT_B2: op_b = i_ch ? hrow_r[1*IB +: IB] : hrow_l[1*IB +: IB];
          SLOT_A1: op_b = i_ch ? hrow_r[2*IB +: IB] : hrow_l[2*IB +: IB];
          SLOT_A2: op_b = i_ch ? hrow_r[3*IB +: IB] : hrow_l[3*IB +: IB];
          default: op_b = '0;
        endcase
      end
      ST_BLEND: begin
        i_vld = (k < 4'd4);
        i_ch  = k[1];
        i_raw = 1'b1;
        op_a  = COEF_BITS'(k[0] ? w_wet : w_dry);
        case (k[1:0])
          2'd0:    op_b = IB'(dry_l);
          2'd1:    op_b = x_l;
          2'd2:    op_b = IB'(dry_r);
          default: op_b = x_r;
        endcase
      end
      default: begin
        i_vld = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    c_re = 1'b0;
    c_we = 1'b0;
    h_re = 1'b0;
    h_we = 1'b0;
    case (state)
      ST_IDLE: begin
        if (ctrl.start) begin
          if (mode == MODE_COEF) begin
            state_next = coef_ok ? ST_CRD : ST_IDLE;
          end else if (enable) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CRD: begin
        c_re = 1'b1;
        state_next = ST_CWR;
      end
      ST_CWR: begin
        c_we = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD: begin
        c_re = 1'b1;
        h_re = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        if (k == 4'd10) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        h_we = 1'b1;
        state_next = (band_cnt == LAST_BAND) ? ST_BLEND : ST_RD;
      end
      ST_BLEND: begin
        if (k == 4'd4) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctrl.take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      p_vld      <= 1'b0;
      hist_valid <= '0;
      coef_valid <= '0;
    end else begin
      state <= state_next;
      p_vld <= i_vld;
      if (h_we) begin
        hist_valid[band_cnt] <= 1'b1;
      end
      if (c_we) begin
        coef_valid[band_cnt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= PW'(op_a) * PW'(op_b);
    p_ch  <= i_ch;
    p_neg <= i_neg;
    p_raw <= i_raw;
    if (p_vld) begin
      if (p_ch) begin
        acc_r <= p_neg ? acc_r - term : acc_r + term;
      end else begin
        acc_l <= p_neg ? acc_l - term : acc_l + term;
      end
    end
    case (state)
      ST_IDLE: begin
        band_cnt <= (mode == MODE_COEF) ? band[BAW-1:0] : '0;
        c_slot   <= coef_slot;
        c_value  <= coef_value;
        dry_l    <= left_sample;
        dry_r    <= right_sample;
        x_l      <= IB'(left_sample);
        x_r      <= IB'(right_sample);
        // bypass: preload so the blend shift returns the input
        acc_l    <= AW'(left_sample) <<< MIX_SHIFT;
        acc_r    <= AW'(right_sample) <<< MIX_SHIFT;
      end
      ST_CRD: begin
        cv <= coef_valid[band_cnt];
      end
      ST_RD: begin
        cv    <= coef_valid[band_cnt];
        hv    <= hist_valid[band_cnt];
        acc_l <= '0;
        acc_r <= '0;
        k     <= '0;
      end
      ST_MAC: begin
        k <= k + 4'd1;
      end
      ST_WB: begin
        x_l <= y_l;
        x_r <= y_r;
        k   <= '0;
        if (band_cnt == LAST_BAND) begin
          acc_l <= '0;
          acc_r <= '0;
        end else begin
          band_cnt <= band_cnt + BAW'(1);
        end
      end
      ST_BLEND: begin
        k <= k + 4'd1;
      end
      default: begin
        k <= k;
      end
    endcase
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

`ifndef SYNTHESIS
  a_prod_source: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> ($past(state) == ST_MAC || $past(state) == ST_BLEND))
    else $error("product issued outside a multiply step");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !ctrl.take) |=> state == ST_DONE)
    else $error("result dropped before it was taken");

  a_coef_rmw: assert property (@(posedge clk) disable iff (rst)
    c_we |-> $past(state) == ST_CRD)
    else $error("coefficient write without a preceding row read");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    h_we |-> int'(band_cnt) < BAND_COUNT)
    else $error("history write beyond the last band");
`endif

endmodule

// ===== design/stereo_graphic_eq_biquad_cascade_top.sv =====
// ----------------------------------------------------------------------------
// stereo_graphic_eq_biquad_cascade_top
// Stereo graphic equalizer: a cascade of direct-form-I biquads per channel
// with a dry/wet blend and an APB register port.
// ----------------------------------------------------------------------------
// A sample request (mode 0) is worked through band by band, and the block
// takes one request at a time. Its run time is set by the single shared
// multiplier: each band needs ten products (five coefficients on each
// channel), plus a row read and a history write-back, and the blend needs
// four more products. With enable off a sample request goes straight to the
// result, and a coefficient request (mode 1) reads, merges and writes back
// one coefficient row and gives no result. Coefficient and history rows sit
// in RAMs with one row per band; a row never written since reset reads as
// identity (coefficients) or zero (history), so no clearing pass is needed.
// A finished result waits in the output register while the next request is
// accepted. Registers: mix_level at byte address 0, enable at byte address
// 4; write them only while idle.
// ----------------------------------------------------------------------------
module stereo_graphic_eq_biquad_cascade_top #(
  parameter int BAND_COUNT     = sgeq_pkg::DEF_BAND_COUNT,
  parameter int SAMPLE_BITS    = sgeq_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = sgeq_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic [4:0]                    band,
  input  logic [2:0]                    coef_slot,
  input  logic signed [31:0]            coef_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import sgeq_pkg::*;

  logic [15:0] mix_level;
  logic        enable;

  eng_ctrl_t ctrl;
  eng_stat_t stat;
  logic signed [SAMPLE_BITS-1:0] eng_left, eng_right;

  // register port: always ready, write in the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_level <= MIX_RESET;
      enable    <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MIX:    mix_level <= pwdata[15:0];
        REG_ENABLE: enable    <= pwdata[0];
        default:    enable    <= enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIX:    prdata = {16'h0000, mix_level};
      REG_ENABLE: prdata = {31'h0, enable};
      default:    prdata = '0;
    endcase
  end

  // hold requests off while the engine works on one
  assign in_stall   = !stat.idle;
  assign ctrl.start = in_valid && stat.idle;
  // advance a finished result when the output register is free
  assign ctrl.take  = stat.done && (!out_valid || !out_stall);

  sgeq_engine #(
    .BAND_COUNT(BAND_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .stat(stat),
    .mode(mode),
    .left_sample(left_sample),
    .right_sample(right_sample),
    .band(band),
    .coef_slot(coef_slot),
    .coef_value(coef_value),
    .mix_level(mix_level),
    .enable(enable),
    .left_out(eng_left),
    .right_out(eng_right)
  );

  // output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      left_out  <= eng_left;
      right_out <= eng_right;
    end
  end

endmodule
